[rtl/shp3_pkg.sv]
// shp3_pkg: shared types and constants for the 3x3 sharpening filter
// item, result and queue record structs, register codes, kernel codes
// used by every module of the block; depends on nothing
package shp3_pkg;

    // line geometry
    localparam int MAX_LINE_BYTES = 4096;
    localparam int COL_W          = $clog2(MAX_LINE_BYTES);
    localparam int ROW_W          = 12;
    localparam int CFG_W          = 13;
    localparam int PIX_W          = 8;
    localparam int WORD_W         = 2 * PIX_W;

    // same-channel neighbour distance in bytes (three bytes per pixel)
    localparam int TAP_STRIDE     = 3;
    localparam int WIN_COLS       = 2 * TAP_STRIDE + 1;
    localparam int WIN_ROWS       = 3;

    // register limits and reset values
    localparam logic [CFG_W-1:0] LINE_BYTES_MIN = CFG_W'(9);
    localparam logic [CFG_W-1:0] LINE_BYTES_MAX = CFG_W'(MAX_LINE_BYTES);
    localparam logic [CFG_W-1:0] LINE_BYTES_RST = CFG_W'(1920);
    localparam logic [CFG_W-1:0] IMAGE_ROWS_MIN = CFG_W'(3);
    localparam logic [CFG_W-1:0] IMAGE_ROWS_MAX = CFG_W'(4096);
    localparam logic [CFG_W-1:0] IMAGE_ROWS_RST = CFG_W'(480);

    // register map: index is paddr[3:2]
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LINE_BYTES  = 2'd0;
    localparam logic [1:0] REG_IMAGE_ROWS  = 2'd1;
    localparam logic [1:0] REG_KERNEL_MODE = 2'd2;

    // kernel codes; the unused code behaves as the all-neighbour kernel
    localparam logic [1:0] KERNEL_BASIC = 2'd0;
    localparam logic [1:0] KERNEL_CROSS = 2'd1;
    localparam logic [1:0] KERNEL_ALL   = 2'd2;

    // filter arithmetic
    localparam int TAP4_W = PIX_W + 2;
    localparam int SUM_W  = 13;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam logic [1:0] TRAIL_ZEROS = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_byte;
        logic             frame_start;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_byte;
        logic             run_last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] line_bytes;
        logic [CFG_W-1:0] image_rows;
        logic [1:0]       kernel_mode;
    } t_cfg;

    // per-item control decided when the byte enters
    typedef struct packed {
        logic emit_val;
        logic interior;
        logic trail;
    } t_item_ctl;

    // one queued record: an optional filtered byte and optionally three border zeros
    typedef struct packed {
        logic             has_val;
        logic [PIX_W-1:0] val;
        logic             trail;
    } t_rec;

endpackage

[rtl/shp3_cfg_regs.sv]
// shp3_cfg_regs: register file behind the APB-style configuration port
// saturates line_bytes and image_rows on write; depends on shp3_pkg
module shp3_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shp3_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output shp3_pkg::t_cfg              o_cfg
);

    shp3_pkg::t_cfg                 r_cfg;
    shp3_pkg::t_cfg                 n_cfg;
    logic [shp3_pkg::CFG_W-1:0]     wr_val;
    logic [1:0]                     reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[shp3_pkg::CFG_W-1:0];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // write decode with saturation
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                shp3_pkg::REG_LINE_BYTES: begin
                    if (wr_val < shp3_pkg::LINE_BYTES_MIN) begin
                        n_cfg.line_bytes = shp3_pkg::LINE_BYTES_MIN;
                    end else if (wr_val > shp3_pkg::LINE_BYTES_MAX) begin
                        n_cfg.line_bytes = shp3_pkg::LINE_BYTES_MAX;
                    end else begin
                        n_cfg.line_bytes = wr_val;
                    end
                end
                shp3_pkg::REG_IMAGE_ROWS: begin
                    if (wr_val < shp3_pkg::IMAGE_ROWS_MIN) begin
                        n_cfg.image_rows = shp3_pkg::IMAGE_ROWS_MIN;
                    end else if (wr_val > shp3_pkg::IMAGE_ROWS_MAX) begin
                        n_cfg.image_rows = shp3_pkg::IMAGE_ROWS_MAX;
                    end else begin
                        n_cfg.image_rows = wr_val;
                    end
                end
                shp3_pkg::REG_KERNEL_MODE: begin
                    n_cfg.kernel_mode = pwdata[1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_bytes  <= shp3_pkg::LINE_BYTES_RST;
            r_cfg.image_rows  <= shp3_pkg::IMAGE_ROWS_RST;
            r_cfg.kernel_mode <= shp3_pkg::KERNEL_BASIC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            shp3_pkg::REG_LINE_BYTES:  prdata = 32'(r_cfg.line_bytes);
            shp3_pkg::REG_IMAGE_ROWS:  prdata = 32'(r_cfg.image_rows);
            shp3_pkg::REG_KERNEL_MODE: prdata = 32'(r_cfg.kernel_mode);
            default:                   prdata = '0;
        endcase
    end

endmodule

[rtl/shp3_line_store.sv]
// shp3_line_store: the two previous image rows in one 4096 x 16 memory
// read at item entry, written back in the next cycle with forwarding; depends on shp3_pkg
module shp3_line_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req,
    input  logic [shp3_pkg::COL_W-1:0]       i_addr,
    input  logic [shp3_pkg::PIX_W-1:0]       i_pix,
    output logic                             o_valid,
    output logic [shp3_pkg::PIX_W-1:0]       o_top,
    output logic [shp3_pkg::PIX_W-1:0]       o_mid,
    output logic [shp3_pkg::PIX_W-1:0]       o_pix
);

    // word layout: upper byte is two rows up, lower byte is one row up
    logic [shp3_pkg::WORD_W-1:0] mem [shp3_pkg::MAX_LINE_BYTES];

    logic                         r_valid;
    logic [shp3_pkg::COL_W-1:0]   r_addr;
    logic [shp3_pkg::PIX_W-1:0]   r_pix;
    logic [shp3_pkg::WORD_W-1:0]  r_rd;
    logic                         r_fwd_hit;
    logic [shp3_pkg::WORD_W-1:0]  r_fwd_word;
    logic [shp3_pkg::WORD_W-1:0]  eff_word;
    logic [shp3_pkg::WORD_W-1:0]  wr_word;

    // a read that met the write of the same column sees the written word
    assign eff_word = r_fwd_hit ? r_fwd_word : r_rd;
    assign wr_word  = {eff_word[shp3_pkg::PIX_W-1:0], r_pix};

    assign o_valid = r_valid;
    assign o_top   = eff_word[shp3_pkg::WORD_W-1:shp3_pkg::PIX_W];
    assign o_mid   = eff_word[shp3_pkg::PIX_W-1:0];
    assign o_pix   = r_pix;

    // memory read and write-back ports
    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_rd <= mem[i_addr];
        end
        if (r_valid) begin
            mem[r_addr] <= wr_word;
        end
    end

    // address, pixel and forwarding capture
    always_ff @(posedge i_clk) begin
        if (i_req) begin
            r_addr     <= i_addr;
            r_pix      <= i_pix;
            r_fwd_hit  <= r_valid && (r_addr == i_addr);
            r_fwd_word <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req;
        end
    end

endmodule

[rtl/shp3_filter.sv]
// shp3_filter: 3 x 7 byte window and the two-stage kernel arithmetic
// builds at most one queue record per item; depends on shp3_pkg
module shp3_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [shp3_pkg::PIX_W-1:0]  i_top,
    input  logic [shp3_pkg::PIX_W-1:0]  i_mid,
    input  logic [shp3_pkg::PIX_W-1:0]  i_pix,
    input  shp3_pkg::t_item_ctl         i_ctl,
    input  logic [1:0]                  i_mode,
    output logic                        o_push,
    output shp3_pkg::t_rec              o_rec,
    output logic [1:0]                  o_busy
);

    localparam int S = shp3_pkg::TAP_STRIDE;
    localparam int L = shp3_pkg::WIN_COLS - 1;

    logic [shp3_pkg::PIX_W-1:0] r_win [shp3_pkg::WIN_ROWS][shp3_pkg::WIN_COLS];

    logic                          r_s2_valid;
    shp3_pkg::t_item_ctl           r_s2_ctl;
    logic                          r_s3_valid;
    shp3_pkg::t_item_ctl           r_s3_ctl;
    logic [shp3_pkg::TAP4_W-1:0]   r_corners;
    logic [shp3_pkg::TAP4_W-1:0]   r_edges;
    logic [shp3_pkg::PIX_W-1:0]    r_centre;

    logic [shp3_pkg::TAP4_W-1:0]   corners;
    logic [shp3_pkg::TAP4_W-1:0]   edges;
    logic signed [shp3_pkg::SUM_W-1:0] s_corners;
    logic signed [shp3_pkg::SUM_W-1:0] s_edges;
    logic signed [shp3_pkg::SUM_W-1:0] s_centre;
    logic signed [shp3_pkg::SUM_W-1:0] sum;
    logic [shp3_pkg::PIX_W-1:0]    clamped;

    // window shift: new column enters on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < shp3_pkg::WIN_ROWS; i++) begin
                for (int j = 0; j < shp3_pkg::WIN_COLS; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_valid) begin
            for (int i = 0; i < shp3_pkg::WIN_ROWS; i++) begin
                for (int j = 0; j < L; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            r_win[0][L] <= i_top;
            r_win[1][L] <= i_mid;
            r_win[2][L] <= i_pix;
        end
    end

    // stage two: group the taps
    assign corners = shp3_pkg::TAP4_W'(r_win[0][0]) + shp3_pkg::TAP4_W'(r_win[0][L])
                   + shp3_pkg::TAP4_W'(r_win[2][0]) + shp3_pkg::TAP4_W'(r_win[2][L]);
    assign edges   = shp3_pkg::TAP4_W'(r_win[0][S]) + shp3_pkg::TAP4_W'(r_win[1][0])
                   + shp3_pkg::TAP4_W'(r_win[1][L]) + shp3_pkg::TAP4_W'(r_win[2][S]);

    always_ff @(posedge i_clk) begin
        r_s2_ctl  <= i_ctl;
        r_s3_ctl  <= r_s2_ctl;
        r_corners <= corners;
        r_edges   <= edges;
        r_centre  <= r_win[1][S];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage three: weight by kernel and clamp to a byte
    assign s_corners = shp3_pkg::SUM_W'(r_corners);
    assign s_edges   = shp3_pkg::SUM_W'(r_edges);
    assign s_centre  = shp3_pkg::SUM_W'(r_centre);

    always_comb begin
        case (i_mode)
            shp3_pkg::KERNEL_BASIC: sum = s_corners - (s_edges <<< 1)
                                        + (s_centre <<< 2) + s_centre;
            shp3_pkg::KERNEL_CROSS: sum = (s_centre <<< 2) + s_centre - s_edges;
            default:                sum = (s_centre <<< 3) + s_centre - s_edges - s_corners;
        endcase
    end

    always_comb begin
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > shp3_pkg::SUM_W'(shp3_pkg::PIX_MAX)) begin
            clamped = shp3_pkg::PIX_MAX;
        end else begin
            clamped = sum[shp3_pkg::PIX_W-1:0];
        end
    end

    assign o_rec.has_val = r_s3_ctl.emit_val;
    assign o_rec.val     = r_s3_ctl.interior ? clamped : '0;
    assign o_rec.trail   = r_s3_ctl.trail;
    assign o_push        = r_s3_valid && (r_s3_ctl.emit_val || r_s3_ctl.trail);
    assign o_busy        = {1'b0, r_s2_valid} + {1'b0, r_s3_valid};

endmodule

[rtl/shp3_out_queue.sv]
// shp3_out_queue: record queue and result emitter on the output channel
// expands a record into its byte plus optional three border zeros, or into the zeros alone; depends on shp3_pkg
module shp3_out_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  shp3_pkg::t_rec                   i_rec,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output shp3_pkg::t_out_item              o_out_data,
    output logic [shp3_pkg::FIFO_CNT_W-1:0]  o_count
);

    shp3_pkg::t_rec r_fifo [shp3_pkg::FIFO_DEPTH];

    logic [shp3_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [shp3_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [shp3_pkg::FIFO_CNT_W-1:0] r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    shp3_pkg::t_out_item             r_out_data, n_out_data;
    logic [1:0]                      r_trail_left, n_trail_left;
    logic                            adv;
    logic                            pop;
    shp3_pkg::t_rec                  head;

    assign head = r_fifo[r_rd_ptr];
    assign adv  = !r_out_valid || i_out_ready;
    assign pop  = adv && (r_trail_left == 2'd0) && (r_count != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fifo[r_wr_ptr] <= i_rec;
        end
    end

    // queue pointers
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        case ({i_push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // emitter: record byte first, then the trailing border zeros
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_trail_left = r_trail_left;
        if (adv) begin
            if (r_trail_left != 2'd0) begin
                n_out_valid         = 1'b1;
                n_out_data.out_byte = '0;
                n_out_data.run_last = (r_trail_left == 2'd1);
                n_trail_left        = r_trail_left - 1'b1;
            end else if (pop) begin
                n_out_valid = 1'b1;
                if (head.has_val) begin
                    n_out_data.out_byte = head.val;
                    n_out_data.run_last = !head.trail;
                    n_trail_left        = head.trail ? shp3_pkg::TRAIL_ZEROS : 2'd0;
                end else begin
                    n_out_data.out_byte = '0;
                    n_out_data.run_last = 1'b0;
                    n_trail_left        = shp3_pkg::TRAIL_ZEROS - 1'b1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_trail_left <= 2'd0;
        end else begin
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_trail_left <= n_trail_left;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_count     = r_count;

endmodule

[rtl/sharpen_3x3_kernel_select.sv]
// sharpen_3x3_kernel_select: top level of the 3x3 sharpening filter
// column and row counters, flow control, and the four sub-blocks; depends on shp3_pkg
//
// Takes one byte of an interleaved BGR image per clock in raster order and filters each
// byte with a 3x3 high-pass kernel over same-channel neighbours (basic weighted, cross
// centre 5, or all-neighbour centre 9, chosen by kernel_mode), clamped to 0..255. Input
// row r produces output row r-1 with zero borders; the last byte of each row but row 0
// produces four results (the byte plus three border zeros), which the output side drains
// in turn. The first three bytes of the next row produce no result, so the queue
// absorbs those extra cycles and, with the output channel ready, the input is taken at
// one byte per clock; the input stalls only when results back up on the output side.
// A result passes through the line-store read, the window, the tap sums and the result
// queue. The two previous rows live in one 4096 x 16 synchronous-read memory that is
// read and written once per byte; it needs no clearing after reset. An eight-record queue
// behind the filter lets input continue while results wait on the output channel.
module sharpen_3x3_kernel_select (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  shp3_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output shp3_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shp3_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    shp3_pkg::t_cfg                  cfg;
    logic [shp3_pkg::COL_W-1:0]      r_col, n_col;
    logic [shp3_pkg::ROW_W-1:0]      r_row, n_row;
    logic [shp3_pkg::COL_W-1:0]      col;
    logic [shp3_pkg::ROW_W-1:0]      row;
    logic [shp3_pkg::CFG_W-1:0]      col_inc;
    logic [shp3_pkg::CFG_W-1:0]      row_inc;
    logic                            row_end;
    logic                            accept;
    shp3_pkg::t_item_ctl             ctl;
    shp3_pkg::t_item_ctl             r_s1_ctl;

    logic                            ls_valid;
    logic [shp3_pkg::PIX_W-1:0]      ls_top;
    logic [shp3_pkg::PIX_W-1:0]      ls_mid;
    logic [shp3_pkg::PIX_W-1:0]      ls_pix;
    logic                            flt_push;
    shp3_pkg::t_rec                  flt_rec;
    logic [1:0]                      flt_busy;
    logic [shp3_pkg::FIFO_CNT_W-1:0] q_count;
    logic [shp3_pkg::FIFO_CNT_W:0]   committed;

    shp3_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // every record in flight has a queue slot reserved before its byte is taken
    assign committed  = (shp3_pkg::FIFO_CNT_W+1)'(q_count)
                      + (shp3_pkg::FIFO_CNT_W+1)'(flt_busy)
                      + (shp3_pkg::FIFO_CNT_W+1)'(ls_valid);
    assign o_in_ready = committed < (shp3_pkg::FIFO_CNT_W+1)'(shp3_pkg::FIFO_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    // position of this byte; frame start forces the origin
    assign col     = i_in_data.frame_start ? '0 : r_col;
    assign row     = i_in_data.frame_start ? '0 : r_row;
    assign col_inc = shp3_pkg::CFG_W'(col) + 1'b1;
    assign row_inc = shp3_pkg::CFG_W'(row) + 1'b1;
    assign row_end = col_inc >= cfg.line_bytes;

    // which results this byte causes
    assign ctl.emit_val = (row != '0) && (col >= shp3_pkg::COL_W'(shp3_pkg::TAP_STRIDE));
    assign ctl.interior = (row >= shp3_pkg::ROW_W'(2))
                       && (col >= shp3_pkg::COL_W'(2 * shp3_pkg::TAP_STRIDE))
                       && (col_inc <= cfg.line_bytes);
    assign ctl.trail    = row_end && (row != '0);

    // counter update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = (row_inc >= cfg.image_rows) ? '0 : row_inc[shp3_pkg::ROW_W-1:0];
            end else begin
                n_col = col_inc[shp3_pkg::COL_W-1:0];
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // control rides along with the memory read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= ctl;
        end
    end

    shp3_line_store u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (accept),
        .i_addr  (col),
        .i_pix   (i_in_data.pixel_byte),
        .o_valid (ls_valid),
        .o_top   (ls_top),
        .o_mid   (ls_mid),
        .o_pix   (ls_pix)
    );

    shp3_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ls_valid),
        .i_top   (ls_top),
        .i_mid   (ls_mid),
        .i_pix   (ls_pix),
        .i_ctl   (r_s1_ctl),
        .i_mode  (cfg.kernel_mode),
        .o_push  (flt_push),
        .o_rec   (flt_rec),
        .o_busy  (flt_busy)
    );

    shp3_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (flt_push),
        .i_rec       (flt_rec),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_count     (q_count)
    );

endmodule

[rtl/shp3_chk.sv]
// shp3_chk: port-level checks for the 3x3 sharpening filter
// bound to sharpen_3x3_kernel_select; depends on shp3_pkg
module shp3_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  shp3_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         pwrite,
    input  logic [shp3_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  prdata
);

    logic r_mid_run, n_mid_run;

    // inside a run of results: only border zeros follow the first result
    always_comb begin
        n_mid_run = r_mid_run;
        if (o_out_valid && i_out_ready) begin
            n_mid_run = !o_out_data.run_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_run <= 1'b0;
        end else begin
            r_mid_run <= n_mid_run;
        end
    end

    // reset empties the output side
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // results after the first of a run are border zeros
    a_trail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mid_run |-> o_out_data.out_byte == '0)
        else $error("nonzero byte inside a row-end run");

    // line_bytes reads back inside its saturated range
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && (paddr[3:2] == shp3_pkg::REG_LINE_BYTES)
        |-> (prdata >= 32'(shp3_pkg::LINE_BYTES_MIN))
            && (prdata <= 32'(shp3_pkg::LINE_BYTES_MAX)))
        else $error("line_bytes out of range");

endmodule

bind sharpen_3x3_kernel_select shp3_chk u_shp3_chk (.*);

[verif/tb_sharpen_3x3_kernel_select.sv]
// tb_sharpen_3x3_kernel_select: self-checking testbench for the 3x3 sharpening filter
// drives byte transactions and register writes, predicts every filtered byte and compares
// depends on shp3_pkg and sharpen_3x3_kernel_select
`timescale 1ns / 1ps

module tb_sharpen_3x3_kernel_select;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 120;
    localparam int WIDE_ITEMS    = 24;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_CHECKER,
        FILL_CHECKER_INV
    } t_fill;

    // block ports
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    shp3_pkg::t_in_item            i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    shp3_pkg::t_out_item           o_out_data;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [shp3_pkg::ADDR_W-1:0]   paddr       = '0;
    logic [31:0]                   pwdata      = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // pending byte transactions and filtered bytes still to arrive
    shp3_pkg::t_in_item            pixel_queue [$];
    shp3_pkg::t_out_item           expected_bytes [$];

    // filter state as the block should hold it
    logic [shp3_pkg::PIX_W-1:0]    prev_row [shp3_pkg::MAX_LINE_BYTES];
    logic [shp3_pkg::PIX_W-1:0]    older_row [shp3_pkg::MAX_LINE_BYTES];
    logic [shp3_pkg::PIX_W-1:0]    tap_win [shp3_pkg::WIN_ROWS][shp3_pkg::WIN_COLS];
    int                            col_pos = 0;
    int                            row_pos = 0;
    logic [shp3_pkg::CFG_W-1:0]    cfg_line   = shp3_pkg::LINE_BYTES_RST;
    logic [shp3_pkg::CFG_W-1:0]    cfg_rows   = shp3_pkg::IMAGE_ROWS_RST;
    logic [1:0]                    cfg_kernel = shp3_pkg::KERNEL_BASIC;

    int                  err_count    = 0;
    int                  cycle_count  = 0;
    int                  items_queued = 0;
    int                  in_gap_left  = 0;
    int                  out_stall_left = 0;
    bit                  in_idle_on   = 1'b0;
    bit                  out_idle_on  = 1'b0;

    sharpen_3x3_kernel_select DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sharpen_3x3_kernel_select] ERROR");
            $finish;
        end
    end

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch %0s at cycle %0d: expected %0h, got %0h",
                     what, cycle_count, want, got);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_fill pick_fill();
        int r;
        r = $urandom_range(0, 7);
        if (r < 5)
            return FILL_RANDOM;
        if (r == 5)
            return FILL_EXTREME;
        if (r == 6)
            return FILL_CHECKER;
        return FILL_CHECKER_INV;
    endfunction

    // weighted sum over the same-channel 3x3 neighbourhood, clamped to a byte
    function automatic logic [shp3_pkg::PIX_W-1:0] kernel_out();
        int corners, edges, centre, sum;
        corners = int'(tap_win[0][0]) + int'(tap_win[0][6])
                + int'(tap_win[2][0]) + int'(tap_win[2][6]);
        edges   = int'(tap_win[0][3]) + int'(tap_win[1][0])
                + int'(tap_win[1][6]) + int'(tap_win[2][3]);
        centre  = int'(tap_win[1][3]);
        case (cfg_kernel)
            shp3_pkg::KERNEL_BASIC: sum = corners - 2 * edges + 5 * centre;
            shp3_pkg::KERNEL_CROSS: sum = 5 * centre - edges;
            default:                sum = 9 * centre - edges - corners;
        endcase
        if (sum < 0)
            sum = 0;
        if (sum > 255)
            sum = 255;
        return shp3_pkg::PIX_W'(sum);
    endfunction

    // one accepted byte: update line stores and window, queue the bytes it releases
    task automatic sharpen_predict(input shp3_pkg::t_in_item item);
        shp3_pkg::t_out_item        batch [4];
        int                         n;
        int                         k;
        logic [shp3_pkg::PIX_W-1:0] top;
        logic [shp3_pkg::PIX_W-1:0] mid;
        logic [shp3_pkg::PIX_W-1:0] filt;
        n   = 0;
        top = '0;
        mid = '0;
        if (item.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos < shp3_pkg::MAX_LINE_BYTES) begin
            top = older_row[col_pos];
            mid = prev_row[col_pos];
            older_row[col_pos] = mid;
            prev_row[col_pos]  = item.pixel_byte;
        end
        for (int i = 0; i < shp3_pkg::WIN_ROWS; i++)
            for (int j = 0; j < shp3_pkg::WIN_COLS - 1; j++)
                tap_win[i][j] = tap_win[i][j + 1];
        tap_win[0][6] = top;
        tap_win[1][6] = mid;
        tap_win[2][6] = item.pixel_byte;

        // output row lags the input row by one, border bytes are zero
        if (row_pos >= 1 && col_pos >= 3) begin
            k    = col_pos - 3;
            filt = '0;
            if (row_pos >= 2 && k >= 3 && k + 4 <= int'(cfg_line))
                filt = kernel_out();
            batch[n].out_byte = filt;
            batch[n].run_last = 1'b0;
            n++;
        end

        // row end releases the three trailing border zeros
        if (col_pos + 1 >= int'(cfg_line)) begin
            if (row_pos >= 1) begin
                repeat (3) begin
                    batch[n].out_byte = '0;
                    batch[n].run_last = 1'b0;
                    n++;
                end
            end
            col_pos = 0;
            row_pos = (row_pos + 1 >= int'(cfg_rows)) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end

        if (n > 0)
            batch[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_bytes.push_back(batch[i]);
    endtask

    // input driver: holds each transaction until accepted, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap_left > 0) begin
                i_in_valid  <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end else if (pixel_queue.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_in_data   <= pixel_queue.pop_front();
                in_gap_left <= pick_gap(in_idle_on);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready    <= 1'b0;
            out_stall_left <= 0;
        end else if (out_stall_left > 0) begin
            i_out_ready    <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end else begin
            i_out_ready    <= 1'b1;
            out_stall_left <= pick_gap(out_idle_on);
        end
    end

    // monitor: check result transactions, then predict from accepted input
    always @(posedge i_clk) begin : monitor
        shp3_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch("unexpected result", '0, 32'(o_out_data));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_data.out_byte !== want.out_byte)
                        note_mismatch("out_byte", 32'(want.out_byte), 32'(o_out_data.out_byte));
                    if (o_out_data.run_last !== want.run_last)
                        note_mismatch("run_last", 32'(want.run_last), 32'(o_out_data.run_last));
                end
            end
            if (i_in_valid && o_in_ready)
                sharpen_predict(i_in_data);
        end
    end

    // register read over the config port, compared with the predicted value
    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            shp3_pkg::REG_LINE_BYTES: want = 32'(cfg_line);
            shp3_pkg::REG_IMAGE_ROWS: want = 32'(cfg_rows);
            default:                  want = 32'(cfg_kernel);
        endcase
        if (prdata !== want)
            note_mismatch($sformatf("register %0d readback", idx), want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write, then the saturated value is read back
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        logic [shp3_pkg::CFG_W-1:0] v;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        v = value[shp3_pkg::CFG_W-1:0];
        case (idx)
            shp3_pkg::REG_LINE_BYTES: begin
                if (v < shp3_pkg::LINE_BYTES_MIN)
                    cfg_line = shp3_pkg::LINE_BYTES_MIN;
                else if (v > shp3_pkg::LINE_BYTES_MAX)
                    cfg_line = shp3_pkg::LINE_BYTES_MAX;
                else
                    cfg_line = v;
            end
            shp3_pkg::REG_IMAGE_ROWS: begin
                if (v < shp3_pkg::IMAGE_ROWS_MIN)
                    cfg_rows = shp3_pkg::IMAGE_ROWS_MIN;
                else if (v > shp3_pkg::IMAGE_ROWS_MAX)
                    cfg_rows = shp3_pkg::IMAGE_ROWS_MAX;
                else
                    cfg_rows = v;
            end
            default: cfg_kernel = value[1:0];
        endcase
        check_reg(idx);
    endtask

    // queue a run of bytes laid out as rows of len bytes
    task automatic queue_bytes(input int count, input int len, input bit mark_start,
                               input t_fill fill, input bit noisy);
        shp3_pkg::t_in_item item;
        int                 col;
        int                 row;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            col = i % len;
            row = i / len;
            case (fill)
                FILL_EXTREME:     item.pixel_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                FILL_CHECKER:     item.pixel_byte = ((col / 3 + row) % 2) ? 8'hFF : 8'h00;
                FILL_CHECKER_INV: item.pixel_byte = ((col / 3 + row) % 2) ? 8'h00 : 8'hFF;
                default:          item.pixel_byte = shp3_pkg::PIX_W'($urandom);
            endcase
            // a stray frame start restarts the image mid-stream
            if (i == 0)
                item.frame_start = mark_start;
            else
                item.frame_start = noisy && ($urandom_range(0, 63) == 0);
            pixel_queue.push_back(item);
        end
        items_queued += count;
    endtask

    // block idle: all bytes in, all results out, pipeline drained
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int                         base;
        int                         len;
        int                         rows;
        int                         n_img;
        bit                         fresh;
        logic [shp3_pkg::CFG_W-1:0] old_line;
        logic [31:0]                wval;

        for (int a = 0; a < shp3_pkg::MAX_LINE_BYTES; a++) begin
            prev_row[a]  = '0;
            older_row[a] = '0;
        end
        for (int i = 0; i < shp3_pkg::WIN_ROWS; i++)
            for (int j = 0; j < shp3_pkg::WIN_COLS; j++)
                tap_win[i][j] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers
        check_reg(shp3_pkg::REG_LINE_BYTES);
        check_reg(shp3_pkg::REG_IMAGE_ROWS);
        check_reg(shp3_pkg::REG_KERNEL_MODE);

        // smallest image, values below the limits saturate up, checker drives clamp to 0
        apb_write(shp3_pkg::REG_LINE_BYTES, 32'd0);
        apb_write(shp3_pkg::REG_IMAGE_ROWS, 32'd0);
        apb_write(shp3_pkg::REG_KERNEL_MODE, 32'(shp3_pkg::KERNEL_BASIC));
        queue_bytes(27, 9, 1'b1, FILL_CHECKER, 1'b0);
        wait_idle();

        // unused kernel code, inverted checker drives clamp to 255
        apb_write(shp3_pkg::REG_KERNEL_MODE, 32'h7);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        queue_bytes(27, 9, 1'b1, FILL_CHECKER_INV, 1'b0);
        wait_idle();

        // random phases: new settings each time, full images with random content
        base = items_queued;
        while (items_queued < base + RANDOM_ITEMS) begin
            old_line = cfg_line;
            case ($urandom_range(0, 9))
                0:       wval = $urandom_range(0, 8);
                1:       wval = 9;
                default: wval = $urandom_range(10, 24);
            endcase
            if ($urandom_range(0, 3) == 0)
                wval[31:shp3_pkg::CFG_W] = (32 - shp3_pkg::CFG_W)'($urandom);
            apb_write(shp3_pkg::REG_LINE_BYTES, wval);
            wval = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            if ($urandom_range(0, 3) == 0)
                wval[31:shp3_pkg::CFG_W] = (32 - shp3_pkg::CFG_W)'($urandom);
            apb_write(shp3_pkg::REG_IMAGE_ROWS, wval);
            wval = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                wval[31:2] = 30'($urandom);
            apb_write(shp3_pkg::REG_KERNEL_MODE, wval);

            // a longer line needs a fresh image so every stored column is written first
            fresh       = (cfg_line > old_line) || ($urandom_range(0, 3) != 0);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            len   = int'(cfg_line);
            rows  = int'(cfg_rows);
            n_img = $urandom_range(1, 2);
            for (int m = 0; m < n_img; m++)
                queue_bytes(len * rows, len, (m == 0) ? fresh : ($urandom_range(0, 5) != 0),
                            pick_fill(), 1'b1);
            // stop part way so the next settings land mid-image
            if ($urandom_range(0, 1) == 1)
                queue_bytes($urandom_range(1, len * rows - 1), len, 1'($urandom_range(0, 1)),
                            pick_fill(), 1'b1);
            wait_idle();
        end

        // longest line: value above the limit saturates to the maximum, part of row 0 only
        apb_write(shp3_pkg::REG_LINE_BYTES, 32'd5000);
        apb_write(shp3_pkg::REG_IMAGE_ROWS, 32'd3);
        apb_write(shp3_pkg::REG_KERNEL_MODE, $urandom_range(0, 3));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        queue_bytes(WIDE_ITEMS, shp3_pkg::MAX_LINE_BYTES, 1'b1, FILL_RANDOM, 1'b0);
        wait_idle();

        // tallest image, then fewer rows while past the new limit
        apb_write(shp3_pkg::REG_LINE_BYTES, 32'd9);
        apb_write(shp3_pkg::REG_IMAGE_ROWS, 32'h1FFF);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        queue_bytes(50, 9, 1'b1, FILL_RANDOM, 1'b0);
        wait_idle();
        apb_write(shp3_pkg::REG_IMAGE_ROWS, 32'd3);
        queue_bytes(40, 9, 1'b0, FILL_EXTREME, 1'b0);
        wait_idle();

        if (err_count == 0 && expected_bytes.size() == 0)
            $display("[sharpen_3x3_kernel_select] OK");
        else
            $display("[sharpen_3x3_kernel_select] ERROR");
        $finish;
    end

endmodule
